// ----- hw/rtl/motor_position_speed_duty_control_defines.svh -----
// Assertion shorthands for the duty controller. Clock and reset are the
// top-level port names.
`ifndef MOTOR_POSITION_SPEED_DUTY_CONTROL_DEFINES_SVH
`define MOTOR_POSITION_SPEED_DUTY_CONTROL_DEFINES_SVH

// same-cycle implication
`define MPSDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MPSDC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/mpsdc_pkg.sv -----
package mpsdc_pkg;

    typedef enum logic [2:0] {
        REG_TARGET_ROT  = 3'd0,
        REG_ROTATION_ON = 3'd1,
        REG_TARGET_SPD  = 3'd2,
        REG_SPEED_ON    = 3'd3,
        REG_GAIN_P      = 3'd4,
        REG_GAIN_I      = 3'd5,
        REG_GAIN_D      = 3'd6,
        REG_INT_LIMIT   = 3'd7
    } cfg_index_t;

    localparam logic [16:0] FULL_DUTY      = 17'd65536;
    localparam logic [16:0] MIN_DUTY       = 17'd13108;
    localparam logic [16:0] HOLD_RESET     = 17'd39322;
    localparam logic [11:0] EARLY_ROTATION = 12'd10;

    localparam logic signed [31:0] GAIN_P_RESET = 32'sd65536;
    localparam logic signed [31:0] GAIN_I_RESET = -32'sd655;
    localparam logic signed [31:0] GAIN_D_RESET = 32'sd13107200;
    localparam logic [15:0]        LIMIT_RESET  = 16'd5000;

    // per-item flags riding along the pipe
    typedef struct packed {
        logic pid;   // PID branch set the duty
        logic hold;  // repeat the previous duty
        logic full;  // speed loop duty: 1 = full, 0 = off
    } tag_t;

    // load strobes for the arithmetic stages
    typedef struct packed {
        logic load_prod;
        logic load_sum;
    } stage_en_t;

endpackage

// ----- hw/rtl/mpsdc_pid_math.sv -----
module mpsdc_pid_math
    import mpsdc_pkg::*;
(
    input  logic               aclk,
    input  stage_en_t          en,
    input  logic signed [12:0] err,
    input  logic signed [31:0] err_sum,
    input  logic signed [13:0] err_diff,
    input  logic signed [31:0] gain_p,
    input  logic signed [31:0] gain_i,
    input  logic signed [31:0] gain_d,
    output logic signed [63:0] pid_sum
);

    logic signed [44:0] prod_p_reg, prod_p_next;
    logic signed [63:0] prod_i_reg, prod_i_next;
    logic signed [45:0] prod_d_reg, prod_d_next;
    logic signed [63:0] sum_reg, sum_next;

    assign prod_p_next = err * gain_p;
    assign prod_i_next = err_sum * gain_i;
    assign prod_d_next = err_diff * gain_d;

    // cannot overflow: integral term tops out at 2^62, the others near 2^44
    assign sum_next = 64'(prod_p_reg) + prod_i_reg + 64'(prod_d_reg);

    always_ff @(posedge aclk) begin
        if (en.load_prod) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
        if (en.load_sum) begin
            sum_reg <= sum_next;
        end
    end

    assign pid_sum = sum_reg;

endmodule

// ----- hw/rtl/motor_position_speed_duty_control.sv -----
// Motor duty controller: each tick transfer carries the rotation count and the
// measured speed and yields one Q1.16 PWM duty plus a flag telling whether the
// position PID (rather than the bang-bang speed loop) set it. The block is a
// four-register pipe: integral/previous-error state updates on input accept,
// then the three gain multipliers, then the PID adder, then clamp, 0.2 dead
// band and duty hold in the output register. One item is taken every cycle; a
// stalled output only blocks input once the pipe is full. The user must write
// configuration through the cfg_* port only while no item is in flight; the
// block does not enforce this. Gains are signed Q16.16 and integral_limit is
// expected to hold 50/|gain_i|.
module motor_position_speed_duty_control
    import mpsdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [11:0] rotation_count, [29:12] measured_speed
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] duty_out
    output logic        m_tuser    // [0] pid_active
);

    // configuration
    logic [9:0]         target_rot_reg;
    logic               rotation_on_reg;
    logic [17:0]        target_spd_reg;
    logic               speed_on_reg;
    logic signed [31:0] gain_p_reg;
    logic signed [31:0] gain_i_reg;
    logic signed [31:0] gain_d_reg;
    logic [15:0]        int_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_rot_reg  <= '0;
            rotation_on_reg <= 1'b0;
            target_spd_reg  <= '0;
            speed_on_reg    <= 1'b0;
            gain_p_reg      <= GAIN_P_RESET;
            gain_i_reg      <= GAIN_I_RESET;
            gain_d_reg      <= GAIN_D_RESET;
            int_limit_reg   <= LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                REG_TARGET_ROT:  target_rot_reg  <= cfg_wdata[9:0];
                REG_ROTATION_ON: rotation_on_reg <= cfg_wdata[0];
                REG_TARGET_SPD:  target_spd_reg  <= cfg_wdata[17:0];
                REG_SPEED_ON:    speed_on_reg    <= cfg_wdata[0];
                REG_GAIN_P:      gain_p_reg      <= cfg_wdata;
                REG_GAIN_I:      gain_i_reg      <= cfg_wdata;
                REG_GAIN_D:      gain_d_reg      <= cfg_wdata;
                REG_INT_LIMIT:   int_limit_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // pipe handshake: each stage loads when empty or when it drains
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdyo;
    logic in_xfer;

    assign rdyo     = !vo_reg || m_tready;
    assign rdy3     = !v3_reg || rdyo;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdyo) vo_reg <= v3_reg;
        end
    end

    // stage 0: branch choice and controller state
    logic [11:0]        count;
    logic [17:0]        speed;
    logic               pid_br, spd_br;
    logic signed [12:0] err;
    logic signed [33:0] acc_sum;
    logic               in_zone, over_lim;
    logic signed [31:0] err_sum_reg, err_sum_next;
    logic signed [12:0] prev_err_reg;
    logic signed [13:0] err_diff;
    tag_t               tag0;

    assign count  = s_tdata[11:0];
    assign speed  = s_tdata[29:12];
    assign pid_br = rotation_on_reg && ({1'b0, count, 1'b0} >= {4'd0, target_rot_reg});
    // outside the PID branch a set rotation target always has 2*count below it
    assign spd_br = speed_on_reg && !pid_br;

    assign err      = $signed({3'd0, target_rot_reg}) - $signed({1'b0, count});
    assign err_diff = 14'(err) - 14'(prev_err_reg);
    assign in_zone  = ($signed({err[12], err, 1'b0}) < $signed({5'd0, target_rot_reg}))
                      && (err != '0);
    assign over_lim = $signed({{5{err[12]}}, err}) > $signed({2'b00, int_limit_reg});
    assign acc_sum  = 34'(err_sum_reg) + 34'(err);

    always_comb begin
        if (!in_zone) begin
            err_sum_next = '0;
        end else if (acc_sum > 34'sh0_7FFF_FFFF) begin
            err_sum_next = 32'sh7FFF_FFFF;
        end else if (acc_sum < -34'sh0_8000_0000) begin
            err_sum_next = 32'sh8000_0000;
        end else begin
            err_sum_next = acc_sum[31:0];
        end
        if (over_lim) begin
            err_sum_next = gain_i_reg[31] ? $signed({16'd0, int_limit_reg})
                                          : -$signed({16'd0, int_limit_reg});
        end
    end

    always_comb begin
        tag0.pid  = pid_br;
        tag0.full = spd_br && ((count < EARLY_ROTATION) || (target_spd_reg > speed));
        // speed loop at exact target speed, or no loop active
        tag0.hold = !pid_br && !(spd_br && (tag0.full || (target_spd_reg < speed)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_sum_reg  <= '0;
            prev_err_reg <= '0;
        end else if (in_xfer && pid_br) begin
            err_sum_reg  <= err_sum_next;
            prev_err_reg <= err;
        end
    end

    // stage 1 register: multiplier operands
    logic signed [12:0] s1_err_reg;
    logic signed [31:0] s1_sum_reg;
    logic signed [13:0] s1_diff_reg;
    tag_t               tag1_reg, tag2_reg, tag3_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_err_reg  <= err;
            s1_sum_reg  <= err_sum_next;
            s1_diff_reg <= err_diff;
            tag1_reg    <= tag0;
        end
        if (rdy2) tag2_reg <= tag1_reg;
        if (rdy3) tag3_reg <= tag2_reg;
    end

    // stages 2 and 3: products, then the PID sum
    stage_en_t          math_en;
    logic signed [63:0] pid_sum;

    assign math_en.load_prod = rdy2;
    assign math_en.load_sum  = rdy3;

    mpsdc_pid_math u_math (
        .aclk     (aclk),
        .en       (math_en),
        .err      (s1_err_reg),
        .err_sum  (s1_sum_reg),
        .err_diff (s1_diff_reg),
        .gain_p   (gain_p_reg),
        .gain_i   (gain_i_reg),
        .gain_d   (gain_d_reg),
        .pid_sum  (pid_sum)
    );

    // output stage: clamp, dead band, hold
    logic [16:0] pid_duty, duty_next;
    logic [16:0] duty_hold_reg;
    logic [16:0] duty_reg;
    logic        pid_act_reg;

    always_comb begin
        if (pid_sum[63] || (pid_sum < 64'sd13108)) begin
            pid_duty = '0;
        end else if (pid_sum > 64'sd65536) begin
            pid_duty = FULL_DUTY;
        end else begin
            pid_duty = pid_sum[16:0];
        end
        if (tag3_reg.pid) begin
            duty_next = pid_duty;
        end else if (tag3_reg.hold) begin
            duty_next = duty_hold_reg;
        end else begin
            duty_next = tag3_reg.full ? FULL_DUTY : '0;
        end
    end

    logic out_load;
    assign out_load = rdyo && v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_hold_reg <= HOLD_RESET;
        end else if (out_load) begin
            duty_hold_reg <= duty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            duty_reg    <= duty_next;
            pid_act_reg <= tag3_reg.pid;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {7'd0, duty_reg};
    assign m_tuser  = pid_act_reg;

`include "motor_position_speed_duty_control_defines.svh"

    `MPSDC_ASSERT_IMP(a_ready_only_stalls_when_full, !s_tready, v1_reg)
    `MPSDC_ASSERT_IMP(a_duty_in_range, m_tvalid, duty_reg <= FULL_DUTY)
    `MPSDC_ASSERT_IMP(a_pid_dead_band, m_tvalid && m_tuser,
        (duty_reg == '0) || (duty_reg >= MIN_DUTY))
    `MPSDC_ASSERT_NXT(a_hold_tracks_output, out_load, duty_hold_reg == duty_reg)

endmodule
